// ===== rtl/tsaq_pkg.sv =====
// tsaq_pkg: shared types, request/status/operator codes and sizing constants
// for the two-stack aggregate queue. No dependencies.

package tsaq_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  // Fixed payload field widths
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 3;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Fold operator codes; anything else folds as a wrapping sum
  localparam logic [OP_W-1:0] OP_SUM = 3'd0;
  localparam logic [OP_W-1:0] OP_MIN = 3'd1;
  localparam logic [OP_W-1:0] OP_MAX = 3'd2;
  localparam logic [OP_W-1:0] OP_AND = 3'd3;
  localparam logic [OP_W-1:0] OP_OR  = 3'd4;
  localparam logic [OP_W-1:0] OP_XOR = 3'd5;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [FIELD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  front_value;
    logic [FIELD_W-1:0]  fold_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Decoded request as held in the command queue
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               query;
    logic               clear;
    logic [FIELD_W-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/tsaq_front.sv =====
// tsaq_front: accepts requests, decodes them and buffers them in a short
// command queue for the back end. Depends on tsaq_pkg.

module tsaq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tsaq_pkg::in_item_t in_item,
  output logic              q_valid,
  output tsaq_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);

  tsaq_pkg::cmd_t                cq_r [tsaq_pkg::CQ_DEPTH];
  logic [tsaq_pkg::CQ_AW-1:0]    wp_r, wp_nxt;
  logic [tsaq_pkg::CQ_AW-1:0]    rp_r, rp_nxt;
  logic [tsaq_pkg::CQ_CW-1:0]    cnt_r, cnt_nxt;
  tsaq_pkg::cmd_t                dec;
  logic                          accept;
  logic                          do_pop;

  always_comb begin
    dec       = '0;
    dec.value = in_item.push_value;
    case (in_item.req_type)
      tsaq_pkg::REQ_PUSH:  dec.push  = 1'b1;
      tsaq_pkg::REQ_POP:   dec.pop   = 1'b1;
      tsaq_pkg::REQ_QUERY: dec.query = 1'b1;
      tsaq_pkg::REQ_CLEAR: dec.clear = 1'b1;
      default:             dec.clear = 1'b1;
    endcase
  end

  assign busy    = (cnt_r == tsaq_pkg::CQ_CW'(tsaq_pkg::CQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = cq_r[rp_r];
  assign accept  = start && !busy;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      wp_nxt = (wp_r == tsaq_pkg::CQ_AW'(tsaq_pkg::CQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == tsaq_pkg::CQ_AW'(tsaq_pkg::CQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (accept && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cq_r[wp_r] <= dec;
    end
  end

endmodule

// ===== rtl/tsaq_back.sv =====
// tsaq_back: executes queued requests on the two stacks (back stack with
// running fold, front stack with suffix folds) and registers one result per
// request. Depends on tsaq_pkg.

module tsaq_back #(
  parameter int QUEUE_DEPTH = tsaq_pkg::DEF_QUEUE_DEPTH,
  parameter int VALUE_WIDTH = tsaq_pkg::DEF_VALUE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tsaq_pkg::OP_W-1:0]   cfg_wdata,
  input  logic                        q_valid,
  input  tsaq_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  output tsaq_pkg::out_item_t         out_item
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = (VALUE_WIDTH > tsaq_pkg::FIELD_W) ? VALUE_WIDTH : tsaq_pkg::FIELD_W;
  localparam int EW = (CW > tsaq_pkg::COUNT_W) ? CW : tsaq_pkg::COUNT_W;

  localparam logic [1:0] S_EXEC = 2'd0;
  localparam logic [1:0] S_XFER = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  function automatic logic [VALUE_WIDTH-1:0] combine(
    input logic [tsaq_pkg::OP_W-1:0] op,
    input logic [VALUE_WIDTH-1:0]    older,
    input logic [VALUE_WIDTH-1:0]    newer
  );
    case (op)
      tsaq_pkg::OP_MIN: combine = (older < newer) ? older : newer;
      tsaq_pkg::OP_MAX: combine = (older > newer) ? older : newer;
      tsaq_pkg::OP_AND: combine = older & newer;
      tsaq_pkg::OP_OR:  combine = older | newer;
      tsaq_pkg::OP_XOR: combine = older ^ newer;
      default:          combine = older + newer;
    endcase
  endfunction

  logic [VALUE_WIDTH-1:0] back_mem  [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] front_mem [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] suf_mem   [QUEUE_DEPTH];

  logic [tsaq_pkg::OP_W-1:0] op_r;
  logic [1:0]                state_r, state_nxt;
  logic [CW-1:0]             fd_r, fd_nxt;
  logic [CW-1:0]             bd_r, bd_nxt;
  logic [VALUE_WIDTH-1:0]    brf_r, brf_nxt;
  logic [VALUE_WIDTH-1:0]    last_suf_r, last_suf_nxt;
  logic                      xv_r, xv_nxt;
  logic [VALUE_WIDTH-1:0]    back_rd_r, front_rd_r, suf_rd_r;
  logic                      out_valid_r;
  tsaq_pkg::out_item_t       out_item_r;

  logic [XW-1:0]             in_ext, front_ext, fold_ext;
  logic [EW-1:0]             cnt_ext;
  logic [VALUE_WIDTH-1:0]    pv;
  logic [CW-1:0]             count, cnt_nxt;
  logic [CW-1:0]             ftop, btop;
  logic                      back_we, front_we;
  logic [VALUE_WIDTH-1:0]    suffix;
  logic                      res_valid;
  logic [tsaq_pkg::STATUS_W-1:0] res_status;
  logic [VALUE_WIDTH-1:0]    res_front, res_fold;

  always_comb begin
    in_ext                        = '0;
    in_ext[tsaq_pkg::FIELD_W-1:0] = q_cmd.value;
    pv                            = in_ext[VALUE_WIDTH-1:0];
  end

  assign count  = fd_r + bd_r;
  assign ftop   = fd_r - 1'b1;
  assign btop   = bd_r - 1'b1;
  assign suffix = (fd_r == '0) ? back_rd_r : combine(op_r, back_rd_r, last_suf_r);

  always_comb begin
    state_nxt    = state_r;
    fd_nxt       = fd_r;
    bd_nxt       = bd_r;
    brf_nxt      = brf_r;
    last_suf_nxt = last_suf_r;
    xv_nxt       = 1'b0;
    back_we      = 1'b0;
    front_we     = 1'b0;
    q_pop        = 1'b0;
    res_valid    = 1'b0;
    res_status   = tsaq_pkg::ST_OK;
    res_front    = '0;
    res_fold     = '0;
    case (state_r)
      S_EXEC: begin
        if (q_valid) begin
          if (q_cmd.push) begin
            q_pop     = 1'b1;
            res_valid = 1'b1;
            if (count >= CW'(QUEUE_DEPTH)) begin
              res_status = tsaq_pkg::ST_FULL;
            end else begin
              back_we = 1'b1;
              brf_nxt = (bd_r == '0) ? pv : combine(op_r, brf_r, pv);
              bd_nxt  = bd_r + 1'b1;
            end
          end else if (q_cmd.clear) begin
            q_pop     = 1'b1;
            res_valid = 1'b1;
            fd_nxt    = '0;
            bd_nxt    = '0;
            brf_nxt   = '0;
          end else if (count == '0) begin
            q_pop      = 1'b1;
            res_valid  = 1'b1;
            res_status = tsaq_pkg::ST_EMPTY;
          end else if (fd_r == '0) begin
            // front stack dry: move the whole back stack over first
            state_nxt = S_XFER;
          end else if (q_cmd.pop) begin
            q_pop     = 1'b1;
            res_valid = 1'b1;
            fd_nxt    = fd_r - 1'b1;
          end else begin
            // top of front stack is captured by the read registers this edge
            state_nxt = S_READ;
          end
        end
      end
      S_XFER: begin
        // one element per cycle: read back top, write front in the next cycle
        if (bd_r != '0) begin
          bd_nxt = bd_r - 1'b1;
          xv_nxt = 1'b1;
        end
        if (xv_r) begin
          front_we     = 1'b1;
          last_suf_nxt = suffix;
          fd_nxt       = fd_r + 1'b1;
        end
        if (bd_r == '0) begin
          brf_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_READ: begin
        q_pop     = 1'b1;
        res_valid = 1'b1;
        res_front = front_rd_r;
        res_fold  = (bd_r != '0) ? combine(op_r, suf_rd_r, brf_r) : suf_rd_r;
        state_nxt = S_EXEC;
      end
      default: begin
        state_nxt = S_EXEC;
      end
    endcase
  end

  assign cnt_nxt = fd_nxt + bd_nxt;

  always_comb begin
    front_ext                  = '0;
    front_ext[VALUE_WIDTH-1:0] = res_front;
    fold_ext                   = '0;
    fold_ext[VALUE_WIDTH-1:0]  = res_fold;
    cnt_ext                    = '0;
    cnt_ext[CW-1:0]            = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= tsaq_pkg::OP_SUM;
      state_r     <= S_EXEC;
      fd_r        <= '0;
      bd_r        <= '0;
      brf_r       <= '0;
      xv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        op_r <= cfg_wdata;
      end
      state_r     <= state_nxt;
      fd_r        <= fd_nxt;
      bd_r        <= bd_nxt;
      brf_r       <= brf_nxt;
      xv_r        <= xv_nxt;
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    last_suf_r             <= last_suf_nxt;
    out_item_r.front_value <= front_ext[tsaq_pkg::FIELD_W-1:0];
    out_item_r.fold_value  <= fold_ext[tsaq_pkg::FIELD_W-1:0];
    out_item_r.entry_count <= cnt_ext[tsaq_pkg::COUNT_W-1:0];
    out_item_r.is_empty    <= (cnt_nxt == '0);
    out_item_r.status      <= res_status;
  end

  // back stack memory
  always_ff @(posedge clk) begin
    if (back_we) begin
      back_mem[bd_r[AW-1:0]] <= pv;
    end
    back_rd_r <= back_mem[btop[AW-1:0]];
  end

  // front stack memories: values and suffix folds
  always_ff @(posedge clk) begin
    if (front_we) begin
      front_mem[fd_r[AW-1:0]] <= back_rd_r;
      suf_mem[fd_r[AW-1:0]]   <= suffix;
    end
    front_rd_r <= front_mem[ftop[AW-1:0]];
    suf_rd_r   <= suf_mem[ftop[AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fd_r} + {1'b0, bd_r}) <= (CW + 1)'(QUEUE_DEPTH))
    else $error("stack depths exceed queue depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (fd_r != '0))
    else $error("query read with empty front stack");

  a_xfer_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XFER && xv_r) |-> (fd_r < CW'(QUEUE_DEPTH)))
    else $error("transfer writes past front stack");

  a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(q_valid))
    else $error("result without a queued item");

endmodule

// ===== rtl/two_stack_aggregate_queue.sv =====
// two_stack_aggregate_queue: top level, FIFO with fold of its contents.
// Instantiates tsaq_front and tsaq_back; depends on tsaq_pkg.
//
// Usage:
//   Requests enter on in_item when start is high and busy is low. busy rises
//   only when the two-entry command queue is full.
//   Each request gives exactly one result on out_item, marked by out_valid
//   for a single cycle; the receiver cannot stall, so results are never held.
//   cfg_we/cfg_wdata write the fold operator; write it only while idle.
//   Push, pop, clear and error results pass through the command queue and
//   the result register; a query also passes through the front stack read.
//   When a pop or query finds the front stack empty, the back stack moves
//   over one element per cycle, set by the single read port of the back
//   stack memory. Each element moves once; pushes run at one per cycle
//   while no transfer or query read holds up the command queue.
//   Reset (synchronous, rst_n low) empties both stacks, clears the running
//   fold and selects the wrapping sum operator. No memory clearing pass.

module two_stack_aggregate_queue #(
  parameter int QUEUE_DEPTH = tsaq_pkg::DEF_QUEUE_DEPTH,
  parameter int VALUE_WIDTH = tsaq_pkg::DEF_VALUE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  tsaq_pkg::in_item_t        in_item,
  output logic                      out_valid,
  output tsaq_pkg::out_item_t       out_item,
  input  logic                      cfg_we,
  input  logic [tsaq_pkg::OP_W-1:0] cfg_wdata
);

  logic           q_valid;
  logic           q_pop;
  tsaq_pkg::cmd_t q_cmd;

  tsaq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  tsaq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
